// ===== hw/rtl/vector_distance_accumulator_defines.svh =====
// Assertion macros for the vector distance accumulator.
// Included by the top level; depends on nothing else.
`ifndef VECTOR_DISTANCE_ACCUMULATOR_DEFINES_SVH
`define VECTOR_DISTANCE_ACCUMULATOR_DEFINES_SVH
`ifndef ASSERT_OFF
`define VDA_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define VDA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) ante |=> cons) else $error(msg);
`else
`define VDA_ASSERT(lbl, clk, rst_n, prop, msg)
`define VDA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== hw/rtl/vda_pkg.sv =====
// Package for the vector distance accumulator: codes, constants and
// single precision arithmetic functions. Depends on nothing.
package vda_pkg;

    localparam int ELEM_W = 32;
    localparam int CFG_W  = 13;

    localparam logic [1:0] KIND_BYTE  = 2'd0;
    localparam logic [1:0] KIND_FLOAT = 2'd1;
    localparam logic [1:0] METRIC_L2  = 2'd0;
    localparam logic [1:0] METRIC_IP  = 2'd1;

    localparam logic [1:0] CFG_ELEMENT_KIND    = 2'd0;
    localparam logic [1:0] CFG_DISTANCE_METRIC = 2'd1;
    localparam logic [1:0] CFG_VECTOR_LENGTH   = 2'd2;

    localparam logic [12:0] LENGTH_RESET = 13'd128;

    localparam logic [31:0] FLT_MAX_BITS = 32'h7F7F_FFFF;
    localparam logic [31:0] CANON_NAN    = 32'h7FC0_0000;
    localparam logic [31:0] ONE_BITS     = 32'h3F80_0000;
    localparam logic [31:0] SIGN_BIT     = 32'h8000_0000;

    function automatic logic is_nan(input logic [31:0] a);
        return (&a[30:23]) && (|a[22:0]);
    endfunction

    function automatic logic is_inf(input logic [31:0] a);
        return (&a[30:23]) && !(|a[22:0]);
    endfunction

    // Round to nearest even addition, subnormals included.
    function automatic logic [31:0] f_add(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] x, y, r;
        logic        sx, sy, found, g, rs, up;
        logic [7:0]  ex, ey, diff;
        logic [23:0] mx, my, m;
        logic [4:0]  sh, lz, lsh;
        logic [26:0] ext, shifted, mask, norm;
        logic        sticky;
        logic [27:0] sum;
        logic [8:0]  e;
        logic [24:0] m25;
        int          i;
        if (a[30:0] >= b[30:0]) begin
            x = a;
            y = b;
        end else begin
            x = b;
            y = a;
        end
        sx = x[31];
        sy = y[31];
        ex = (x[30:23] == 8'd0) ? 8'd1 : x[30:23];
        ey = (y[30:23] == 8'd0) ? 8'd1 : y[30:23];
        mx = {|x[30:23], x[22:0]};
        my = {|y[30:23], y[22:0]};
        diff = ex - ey;
        sh = (diff > 8'd31) ? 5'd31 : diff[4:0];
        ext = {my, 3'b000};
        shifted = ext >> sh;
        mask = ~({27{1'b1}} << sh);
        sticky = |(ext & mask);
        shifted[0] = shifted[0] | sticky;
        if (sx == sy) begin
            sum = {1'b0, mx, 3'b000} + {1'b0, shifted};
        end else begin
            sum = {1'b0, mx, 3'b000} - {1'b0, shifted};
        end
        e = {1'b0, ex};
        lz = 5'd0;
        found = 1'b0;
        for (i = 26; i >= 0; i--) begin
            if (!found && sum[i]) begin
                lz = 5'(26 - i);
                found = 1'b1;
            end
        end
        if (sum[27]) begin
            norm = {sum[27:2], sum[1] | sum[0]};
            e = e + 9'd1;
        end else begin
            lsh = ({4'b0, lz} > (e - 9'd1)) ? 5'(e - 9'd1) : lz;
            norm = sum[26:0] << lsh;
            e = e - {4'b0, lsh};
        end
        g = norm[2];
        rs = norm[1] | norm[0];
        up = g & (rs | norm[3]);
        m25 = {1'b0, norm[26:3]} + {24'b0, up};
        if (m25[24]) begin
            m = m25[24:1];
            e = e + 9'd1;
        end else begin
            m = m25[23:0];
        end
        if (e >= 9'd255) begin
            r = {sx, 8'hFF, 23'b0};
        end else begin
            r = {sx, (m[23] ? e[7:0] : 8'd0), m[22:0]};
        end
        if (sum == 28'd0) begin
            r = {sx & sy, 31'b0};
        end
        if (is_nan(a) || is_nan(b)) begin
            r = CANON_NAN;
        end else if (is_inf(a) && is_inf(b)) begin
            r = (a[31] == b[31]) ? a : CANON_NAN;
        end else if (is_inf(a)) begin
            r = a;
        end else if (is_inf(b)) begin
            r = b;
        end
        return r;
    endfunction

    // Round to nearest even multiplication, subnormals included.
    function automatic logic [31:0] f_mul(input logic [31:0] a, input logic [31:0] b);
        logic               s, found, g, st, up, sticky, a_zero, b_zero;
        logic [7:0]         ea, eb;
        logic [23:0]        ma, mb, m;
        logic [47:0]        p, n, mask;
        logic [5:0]         lz, rsh;
        logic signed [10:0] ee, rdist;
        logic [24:0]        m25;
        logic [31:0]        r;
        int                 i;
        s = a[31] ^ b[31];
        a_zero = (a[30:0] == 31'd0);
        b_zero = (b[30:0] == 31'd0);
        ea = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
        eb = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
        ma = {|a[30:23], a[22:0]};
        mb = {|b[30:23], b[22:0]};
        p = ma * mb;
        lz = 6'd0;
        found = 1'b0;
        for (i = 47; i >= 0; i--) begin
            if (!found && p[i]) begin
                lz = 6'(47 - i);
                found = 1'b1;
            end
        end
        n = p << lz;
        ee = 11'({3'b000, ea}) + 11'({3'b000, eb}) - 11'sd126 - 11'({5'b0, lz});
        if (ee < 11'sd1) begin
            rdist = 11'sd1 - ee;
            rsh = (rdist > 11'sd50) ? 6'd50 : rdist[5:0];
            mask = ~({48{1'b1}} << rsh);
            sticky = |(n & mask);
            n = n >> rsh;
            n[0] = n[0] | sticky;
            ee = 11'sd1;
        end
        g = n[23];
        st = |n[22:0];
        up = g & (st | n[24]);
        m25 = {1'b0, n[47:24]} + {24'b0, up};
        if (m25[24]) begin
            m = m25[24:1];
            ee = ee + 11'sd1;
        end else begin
            m = m25[23:0];
        end
        if (ee >= 11'sd255) begin
            r = {s, 8'hFF, 23'b0};
        end else begin
            r = {s, (m[23] ? ee[7:0] : 8'd0), m[22:0]};
        end
        if (is_nan(a) || is_nan(b)) begin
            r = CANON_NAN;
        end else if ((is_inf(a) && b_zero) || (is_inf(b) && a_zero)) begin
            r = CANON_NAN;
        end else if (is_inf(a) || is_inf(b)) begin
            r = {s, 8'hFF, 23'b0};
        end else if (a_zero || b_zero) begin
            r = {s, 31'b0};
        end
        return r;
    endfunction

    // Exact conversion of a 16-bit unsigned integer.
    function automatic logic [31:0] u16_to_f(input logic [15:0] v);
        logic [3:0]  lz;
        logic [15:0] sh;
        logic        found;
        int          i;
        lz = 4'd0;
        found = 1'b0;
        for (i = 15; i >= 0; i--) begin
            if (!found && v[i]) begin
                lz = 4'(15 - i);
                found = 1'b1;
            end
        end
        sh = v << lz;
        if (v == 16'd0) begin
            return 32'd0;
        end
        return {1'b0, 8'(8'd142 - {4'b0, lz}), sh[14:0], 8'b0};
    endfunction

    function automatic logic [31:0] canon(input logic [31:0] a);
        return is_nan(a) ? CANON_NAN : a;
    endfunction

endpackage

// ===== hw/rtl/vda_in_if.sv =====
// Input channel of the vector distance accumulator: one component pair.
// Depends on vda_pkg.
interface vda_in_if;
    logic                       valid;
    logic                       ready;
    logic [vda_pkg::ELEM_W-1:0] query_elem;
    logic [vda_pkg::ELEM_W-1:0] stored_elem;

    modport source (output valid, output query_elem, output stored_elem, input ready);
    modport sink (input valid, input query_elem, input stored_elem, output ready);
endinterface

// ===== hw/rtl/vda_out_if.sv =====
// Result channel of the vector distance accumulator: one distance.
// Depends on vda_pkg.
interface vda_out_if;
    logic                       valid;
    logic                       ready;
    logic [vda_pkg::ELEM_W-1:0] distance_bits;

    modport source (output valid, output distance_bits, input ready);
    modport sink (input valid, input distance_bits, output ready);
endinterface

// ===== hw/rtl/vector_distance_accumulator.sv =====
// Top level of the vector distance accumulator: input register, subtract,
// multiply, accumulate and result stages. Depends on vda_pkg, the channel
// interfaces and vector_distance_accumulator_defines.svh.
//
//  channel   direction  payload              transfer
//  i_item    in         query/stored elem    valid && ready
//  o_result  out        distance_bits        valid && ready
//  i_cfg_*   in         index, write data    i_cfg_we
//
// One item is taken every cycle when not stalled; the combinational float
// add feeding the accumulator closes the accumulation loop. The last item
// of a vector passes subtract, multiply and accumulate to the result stage.
// Synchronous active-low reset clears the pipeline, sum and count, and
// restores the registers. The pipeline stalls only when a result waits at
// the output and the next one has reached the last stage.
`include "vector_distance_accumulator_defines.svh"

module vector_distance_accumulator #(
    parameter int MAX_LENGTH = 4096
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [1:0]                i_cfg_index,
    input  logic [vda_pkg::CFG_W-1:0] i_cfg_wdata,
    vda_in_if.sink                    i_item,
    vda_out_if.source                 o_result
);

    localparam int CW = $clog2(MAX_LENGTH + 1);
    localparam int LW = (CW > vda_pkg::CFG_W) ? CW : vda_pkg::CFG_W;
    localparam logic [LW-1:0] MAX_LEN = LW'(MAX_LENGTH);

    logic [1:0]                r_kind, r_metric;
    logic [vda_pkg::CFG_W-1:0] r_length;
    logic [31:0]               r_acc;
    logic [CW-1:0]             r_count;

    logic        r_s0_valid;
    logic [31:0] r_s0_q, r_s0_s;
    logic        r_s1_valid;
    logic [31:0] r_s1_a, r_s1_b;
    logic [7:0]  r_s1_absd;
    logic        r_s2_valid, r_s2_add;
    logic [31:0] r_s2_prod;
    logic        r_s3_valid, r_s3_last;
    logic [31:0] r_s3_sum;
    logic        r_out_valid;
    logic [31:0] r_out_bits;

    logic          stall, en;
    logic [LW-1:0] eff_len, cnt_next_w;
    logic          n_last;
    logic [31:0]   n_sum, diff_f, final_bits;
    logic [8:0]    byte_diff;
    logic          f_l2, f_ip, byte_l2;
    logic          count_ok, acc_last, acc_clear, out_canon;

    assign byte_l2 = (r_kind == vda_pkg::KIND_BYTE);
    assign f_l2 = (r_kind == vda_pkg::KIND_FLOAT) && (r_metric == vda_pkg::METRIC_L2);
    assign f_ip = (r_kind == vda_pkg::KIND_FLOAT) && (r_metric == vda_pkg::METRIC_IP);

    assign stall = r_out_valid && !o_result.ready && r_s3_valid && r_s3_last;
    assign en = !stall;
    assign i_item.ready = en;

    always_comb begin
        eff_len = LW'(r_length);
        if (r_length == '0) begin
            eff_len = LW'(1);
        end else if (eff_len > MAX_LEN) begin
            eff_len = MAX_LEN;
        end
    end

    assign cnt_next_w = LW'(r_count) + LW'(1);
    assign n_last = (cnt_next_w >= eff_len);

    assign byte_diff = {1'b0, r_s0_q[7:0]} - {1'b0, r_s0_s[7:0]};
    assign diff_f = vda_pkg::f_add(r_s0_q, r_s0_s ^ vda_pkg::SIGN_BIT);
    assign n_sum = r_s2_add ? vda_pkg::f_add(r_acc, r_s2_prod) : r_acc;

    always_comb begin
        if (byte_l2 || f_l2) begin
            final_bits = r_s3_sum;
        end else if (f_ip) begin
            final_bits = vda_pkg::f_add(vda_pkg::ONE_BITS, r_s3_sum ^ vda_pkg::SIGN_BIT);
        end else begin
            final_bits = vda_pkg::FLT_MAX_BITS;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind <= vda_pkg::KIND_BYTE;
            r_metric <= vda_pkg::METRIC_L2;
            r_length <= vda_pkg::LENGTH_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                vda_pkg::CFG_ELEMENT_KIND:    r_kind <= i_cfg_wdata[1:0];
                vda_pkg::CFG_DISTANCE_METRIC: r_metric <= i_cfg_wdata[1:0];
                vda_pkg::CFG_VECTOR_LENGTH:   r_length <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Pipeline valids, sum and count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
            r_out_valid <= 1'b0;
            r_acc <= '0;
            r_count <= '0;
        end else begin
            if (en) begin
                r_s0_valid <= i_item.valid;
                r_s1_valid <= r_s0_valid;
                r_s2_valid <= r_s1_valid;
                r_s3_valid <= r_s2_valid;
            end
            // A register write abandons any partial vector.
            if (i_cfg_we) begin
                r_acc <= '0;
                r_count <= '0;
            end else if (en && r_s2_valid) begin
                r_acc <= n_last ? '0 : n_sum;
                r_count <= n_last ? '0 : cnt_next_w[CW-1:0];
            end
            if (en && r_s3_valid && r_s3_last) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s0_q <= i_item.query_elem;
            r_s0_s <= i_item.stored_elem;
            r_s1_absd <= byte_diff[8] ? 8'(-byte_diff) : byte_diff[7:0];
            if (f_ip) begin
                r_s1_a <= r_s0_q;
                r_s1_b <= r_s0_s;
            end else begin
                r_s1_a <= diff_f;
                r_s1_b <= diff_f;
            end
            r_s2_prod <= byte_l2 ? vda_pkg::u16_to_f(16'(r_s1_absd) * 16'(r_s1_absd))
                                 : vda_pkg::f_mul(r_s1_a, r_s1_b);
            r_s2_add <= byte_l2 || f_l2 || f_ip;
            r_s3_sum <= n_sum;
            r_s3_last <= n_last;
            if (r_s3_valid && r_s3_last) begin
                r_out_bits <= vda_pkg::canon(final_bits);
            end
        end
    end

    assign o_result.valid = r_out_valid;
    assign o_result.distance_bits = r_out_bits;

    assign count_ok = (LW'(r_count) < eff_len);
    assign acc_last = en && r_s2_valid && n_last;
    assign acc_clear = (r_acc == 32'd0) && (r_count == '0);
    assign out_canon = !vda_pkg::is_nan(r_out_bits) || (r_out_bits == vda_pkg::CANON_NAN);

    `VDA_ASSERT(a_count_below_len, i_clk, i_rst_n, count_ok, "count past length")
    `VDA_ASSERT_NEXT(a_clear_after_last, i_clk, i_rst_n, acc_last, acc_clear, "sum not cleared")
    `VDA_ASSERT(a_nan_canonical, i_clk, i_rst_n, (r_out_valid |-> out_canon), "non-canonical NaN")

endmodule

// ===== tb/sv/vector_distance_accumulator_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for vector_distance_accumulator: a directed table and then random
// vectors under random flow control. Depends on vda_pkg, vda_in_if, vda_out_if and vector_distance_accumulator.
module vector_distance_accumulator_test;

    localparam logic [1:0] CFG_UNUSED = 2'd3;
    localparam int         MAX_LEN    = 4096;
    localparam int         RAND_ITEMS = 1600;

    typedef struct packed {
        logic [1:0]  kind;
        logic [1:0]  metric;
        logic [12:0] len;
        logic [31:0] q;
        logic [31:0] s;
        logic        chk;
        logic [31:0] want_bits;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [12:0] cfg_wdata;

    vda_in_if  in_ch ();
    vda_out_if out_ch ();

    vector_distance_accumulator #(.MAX_LENGTH(MAX_LEN)) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_wdata (cfg_wdata),
        .i_item      (in_ch),
        .o_result    (out_ch)
    );

    // Predictor state, a shadow of the block's registers.
    logic [1:0]  mdl_kind   = vda_pkg::KIND_BYTE;
    logic [1:0]  mdl_metric = vda_pkg::METRIC_L2;
    logic [12:0] mdl_len    = vda_pkg::LENGTH_RESET;
    logic [31:0] mdl_sum    = 32'd0;
    int          mdl_count  = 0;

    logic [31:0] distance_q [$];
    int          errors     = 0;
    logic        row_chk    = 1'b0;
    logic [31:0] row_bits   = 32'd0;
    logic        hold_req   = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic logic [63:0] to_f64(input logic [31:0] f);
        logic [23:0] mm;
        int          e;
        if (f[30:23] == 8'hFF) return {f[31], 11'h7FF, f[22:0], 29'b0};
        if (f[30:0] == 31'd0) return {f[31], 63'b0};
        if (f[30:23] == 8'd0) begin
            mm = {1'b0, f[22:0]};
            e = -126;
            while (!mm[23]) begin
                mm = mm << 1;
                e--;
            end
            return {f[31], 11'(e + 1023), mm[22:0], 29'b0};
        end
        return {f[31], 11'(int'(f[30:23]) + 896), f[22:0], 29'b0};
    endfunction

    // Round a double to single precision, nearest even, subnormals included.
    function automatic logic [31:0] to_f32(input real r);
        logic [63:0] d;
        logic [63:0] mant;
        logic [63:0] kept;
        logic [31:0] mag;
        logic        g, st, up;
        int          e, sh;
        d = $realtobits(r);
        if (d[62:52] == 11'h7FF) begin
            return (d[51:0] != 0) ? vda_pkg::CANON_NAN : {d[63], 8'hFF, 23'b0};
        end
        if (d[62:52] == 11'd0) return {d[63], 31'b0};
        e = int'(d[62:52]) - 1023;
        if (e > 127) return {d[63], 8'hFF, 23'b0};
        mant = {11'b0, 1'b1, d[51:0]};
        sh = (e >= -126) ? 29 : 29 + (-126 - e);
        if (sh > 60) return {d[63], 31'b0};
        kept = mant >> sh;
        g = mant[sh-1];
        st = |(mant & ((64'd1 << (sh - 1)) - 64'd1));
        up = g & (st | kept[0]);
        if (e >= -126) mag = {1'b0, 8'(e + 127), 23'b0} + {9'b0, kept[22:0]} + 32'(up);
        else mag = kept[31:0] + 32'(up);
        if (mag >= 32'h7F80_0000) mag = 32'h7F80_0000;
        return {d[63], mag[30:0]};
    endfunction

    // Double rounding through real is exact enough for single add and multiply.
    function automatic logic [31:0] sp_add(input logic [31:0] a, input logic [31:0] b);
        return to_f32($bitstoreal(to_f64(a)) + $bitstoreal(to_f64(b)));
    endfunction

    function automatic logic [31:0] sp_sub(input logic [31:0] a, input logic [31:0] b);
        return to_f32($bitstoreal(to_f64(a)) - $bitstoreal(to_f64(b)));
    endfunction

    function automatic logic [31:0] sp_mul(input logic [31:0] a, input logic [31:0] b);
        return to_f32($bitstoreal(to_f64(a)) * $bitstoreal(to_f64(b)));
    endfunction

    task automatic accumulate_pair(input logic [31:0] q, input logic [31:0] s,
                                   output logic done, output logic [31:0] res_bits);
        logic [31:0] d;
        logic        byte_l2, flt_l2, flt_ip;
        int          eff;
        byte_l2 = (mdl_kind == vda_pkg::KIND_BYTE);
        flt_l2  = (mdl_kind == vda_pkg::KIND_FLOAT) && (mdl_metric == vda_pkg::METRIC_L2);
        flt_ip  = (mdl_kind == vda_pkg::KIND_FLOAT) && (mdl_metric == vda_pkg::METRIC_IP);
        if (byte_l2) begin
            d = to_f32(real'(int'(q[7:0]) - int'(s[7:0])));
            mdl_sum = sp_add(mdl_sum, sp_mul(d, d));
        end else if (flt_l2) begin
            d = sp_sub(q, s);
            mdl_sum = sp_add(mdl_sum, sp_mul(d, d));
        end else if (flt_ip) begin
            mdl_sum = sp_add(mdl_sum, sp_mul(q, s));
        end
        mdl_count++;
        eff = (mdl_len == 13'd0) ? 1 : ((int'(mdl_len) > MAX_LEN) ? MAX_LEN : int'(mdl_len));
        done = (mdl_count >= eff);
        res_bits = 32'd0;
        if (done) begin
            if (byte_l2 || flt_l2) res_bits = mdl_sum;
            else if (flt_ip) res_bits = sp_sub(vda_pkg::ONE_BITS, mdl_sum);
            else res_bits = vda_pkg::FLT_MAX_BITS;
            if ((&res_bits[30:23]) && (|res_bits[22:0])) res_bits = vda_pkg::CANON_NAN;
            mdl_sum = 32'd0;
            mdl_count = 0;
        end
    endtask

    always @(posedge i_clk) begin
        logic        vec_done;
        logic [31:0] vec_bits;
        logic [31:0] want;
        if (i_rst_n) begin
            if (cfg_we) begin
                case (cfg_index)
                    vda_pkg::CFG_ELEMENT_KIND:    mdl_kind = cfg_wdata[1:0];
                    vda_pkg::CFG_DISTANCE_METRIC: mdl_metric = cfg_wdata[1:0];
                    vda_pkg::CFG_VECTOR_LENGTH:   mdl_len = cfg_wdata;
                    default: ;
                endcase
                mdl_sum = 32'd0;
                mdl_count = 0;
            end
            if (in_ch.valid && in_ch.ready) begin
                accumulate_pair(in_ch.query_elem, in_ch.stored_elem, vec_done, vec_bits);
                if (vec_done) distance_q = {distance_q, (row_chk ? row_bits : vec_bits)};
            end
            if (out_ch.valid && out_ch.ready) begin
                if (distance_q.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result, expected none, got %h",
                             $time, out_ch.distance_bits);
                end else begin
                    want = distance_q.pop_front();
                    if (out_ch.distance_bits !== want) begin
                        errors++;
                        $display("%0t: distance_bits mismatch, expected %h, got %h",
                                 $time, want, out_ch.distance_bits);
                    end
                end
            end
        end
    end

    // The receiver switches among random stall patterns; a long hold-off on request.
    always @(negedge i_clk) begin
        static int hold_cnt = 0;
        static int tick = 0;
        static int mode = 0;
        tick++;
        if (tick % 200 == 0) mode = $urandom_range(0, 3);
        if (hold_cnt > 0) begin
            out_ch.ready <= 1'b0;
            hold_cnt--;
        end else if (hold_req) begin
            hold_cnt = 400;
            hold_req = 1'b0;
            out_ch.ready <= 1'b0;
        end else begin
            case (mode)
                0: out_ch.ready <= 1'b1;
                1: out_ch.ready <= ($urandom_range(0, 3) != 0);
                2: out_ch.ready <= ($urandom_range(0, 3) == 0);
                default: out_ch.ready <= ((tick % 8) < 5);
            endcase
        end
    end

    task automatic wait_idle();
        in_ch.valid = 1'b0;
        while (distance_q.size() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [12:0] val);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_wdata = val;
        @(negedge i_clk);
        cfg_we = 1'b0;
    endtask

    task automatic set_config(input logic [1:0] k, input logic [1:0] m, input logic [12:0] l);
        wait_idle();
        write_reg(vda_pkg::CFG_ELEMENT_KIND, {11'($urandom), k});
        write_reg(vda_pkg::CFG_DISTANCE_METRIC, {11'($urandom), m});
        write_reg(vda_pkg::CFG_VECTOR_LENGTH, l);
    endtask

    // Leaves valid high; the caller lowers it for a gap.
    task automatic send_pair(input logic [31:0] q, input logic [31:0] s);
        in_ch.valid = 1'b1;
        in_ch.query_elem = q;
        in_ch.stored_elem = s;
        do @(posedge i_clk); while (!in_ch.ready);
        @(negedge i_clk);
    endtask

    function automatic logic [31:0] rand_elem();
        logic [31:0] specials [8] = '{32'h0, vda_pkg::SIGN_BIT, 32'h7F80_0000, 32'hFF80_0000,
                                      vda_pkg::CANON_NAN, 32'h1, vda_pkg::FLT_MAX_BITS,
                                      vda_pkg::ONE_BITS};
        case ($urandom_range(0, 9))
            0: return $urandom;
            1: return specials[$urandom_range(0, 7)];
            default: return {1'($urandom), 8'($urandom_range(110, 140)), 23'($urandom)};
        endcase
    endfunction

    t_row dir_rows [0:19];

    initial begin
        logic [1:0]  cur_k, cur_m, k, m;
        logic [12:0] cur_l, l;
        int          total, phase, n, burst, gap, eff;
        logic        first, no_gaps;

        i_rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = vda_pkg::CFG_ELEMENT_KIND;
        cfg_wdata = 13'd0;
        in_ch.valid = 1'b0;
        in_ch.query_elem = 32'd0;
        in_ch.stored_elem = 32'd0;
        dir_rows = '{
            '{vda_pkg::KIND_BYTE, vda_pkg::METRIC_L2, 13'd1, 32'h0, 32'h0, 1'b1, 32'h0},
            '{vda_pkg::KIND_BYTE, vda_pkg::METRIC_L2, 13'd1, 32'hFF, 32'h0, 1'b1,
              32'h477E_0100},
            '{vda_pkg::KIND_BYTE, vda_pkg::METRIC_L2, 13'd1, 32'hFFFF_FF00, 32'hFFFF_FFFF,
              1'b1, 32'h477E_0100},
            '{vda_pkg::KIND_BYTE, 2'd2, 13'd1, 32'h0, 32'hFF, 1'b1, 32'h477E_0100},
            '{vda_pkg::KIND_BYTE, vda_pkg::METRIC_L2, 13'd0, 32'h1, 32'h3, 1'b1,
              32'h4080_0000},
            '{vda_pkg::KIND_FLOAT, vda_pkg::METRIC_L2, 13'd1, vda_pkg::ONE_BITS,
              vda_pkg::ONE_BITS, 1'b1, 32'h0},
            '{vda_pkg::KIND_FLOAT, vda_pkg::METRIC_L2, 13'd1, vda_pkg::FLT_MAX_BITS,
              32'hFF7F_FFFF, 1'b1, 32'h7F80_0000},
            '{vda_pkg::KIND_FLOAT, vda_pkg::METRIC_L2, 13'd1, 32'h7FC0_0001, 32'h0, 1'b1,
              vda_pkg::CANON_NAN},
            '{vda_pkg::KIND_FLOAT, vda_pkg::METRIC_L2, 13'd1, 32'h7F80_0000, 32'h7F80_0000,
              1'b1, vda_pkg::CANON_NAN},
            '{vda_pkg::KIND_FLOAT, vda_pkg::METRIC_L2, 13'd1, 32'h1, 32'h0, 1'b1, 32'h0},
            '{vda_pkg::KIND_FLOAT, vda_pkg::METRIC_IP, 13'd1, 32'h0, 32'h0, 1'b1,
              vda_pkg::ONE_BITS},
            '{vda_pkg::KIND_FLOAT, vda_pkg::METRIC_IP, 13'd1, vda_pkg::ONE_BITS,
              vda_pkg::ONE_BITS, 1'b1, 32'h0},
            '{vda_pkg::KIND_FLOAT, vda_pkg::METRIC_IP, 13'd1, 32'h7F80_0000, 32'h0, 1'b1,
              vda_pkg::CANON_NAN},
            '{vda_pkg::KIND_FLOAT, vda_pkg::METRIC_IP, 13'd1, 32'h7F80_0000,
              vda_pkg::ONE_BITS, 1'b1, 32'hFF80_0000},
            '{vda_pkg::KIND_FLOAT, vda_pkg::METRIC_IP, 13'd1, 32'hFFFF_FFFF, 32'h0, 1'b1,
              vda_pkg::CANON_NAN},
            '{2'd2, vda_pkg::METRIC_L2, 13'd1, vda_pkg::ONE_BITS, 32'h0, 1'b1,
              vda_pkg::FLT_MAX_BITS},
            '{2'd3, 2'd3, 13'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, vda_pkg::FLT_MAX_BITS},
            '{vda_pkg::KIND_FLOAT, 2'd2, 13'd1, vda_pkg::ONE_BITS, vda_pkg::ONE_BITS, 1'b1,
              vda_pkg::FLT_MAX_BITS},
            '{vda_pkg::KIND_FLOAT, vda_pkg::METRIC_L2, 13'd3, 32'h3FC0_0000, 32'hC020_0000,
              1'b0, 32'h0},
            '{vda_pkg::KIND_FLOAT, vda_pkg::METRIC_L2, 13'd3, 32'h0080_0000, 32'h8000_0001,
              1'b0, 32'h0}
        };
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Default registers first: a full 128-item byte vector.
        for (int i = 0; i < 128; i++) send_pair($urandom, $urandom);
        in_ch.valid = 1'b0;

        first = 1'b1;
        foreach (dir_rows[i]) begin
            if (first || dir_rows[i].kind != cur_k || dir_rows[i].metric != cur_m ||
                dir_rows[i].len != cur_l) begin
                cur_k = dir_rows[i].kind;
                cur_m = dir_rows[i].metric;
                cur_l = dir_rows[i].len;
                set_config(cur_k, cur_m, cur_l);
                first = 1'b0;
            end
            row_chk = dir_rows[i].chk;
            row_bits = dir_rows[i].want_bits;
            send_pair(dir_rows[i].q, dir_rows[i].s);
        end
        in_ch.valid = 1'b0;
        row_chk = 1'b0;

        total = 0;
        phase = 0;
        while (total < RAND_ITEMS || phase < 6) begin
            k = ($urandom_range(0, 9) == 0) ? 2'($urandom_range(2, 3)) : 2'($urandom_range(0, 1));
            m = ($urandom_range(0, 9) == 0) ? 2'($urandom_range(2, 3)) : 2'($urandom_range(0, 1));
            case ($urandom_range(0, 9))
                0: l = 13'd0;
                1: l = 13'($urandom_range(17, 64));
                default: l = 13'($urandom_range(1, 16));
            endcase
            if (phase == 1) begin
                k = vda_pkg::KIND_FLOAT;
                m = vda_pkg::METRIC_L2;
                l = 13'd1;
            end else if (phase == 3) begin
                k = vda_pkg::KIND_BYTE;
                l = 13'd100;
            end else if (phase == 5) begin
                k = vda_pkg::KIND_FLOAT;
                m = vda_pkg::METRIC_IP;
                l = 13'h1FFF;
            end
            set_config(k, m, l);
            if (phase % 5 == 4) write_reg(CFG_UNUSED, 13'($urandom));
            eff = (l == 13'd0) ? 1 : ((int'(l) > MAX_LEN) ? MAX_LEN : int'(l));
            // A saturated length gets a partial vector that the next write abandons.
            if (eff >= MAX_LEN) n = 256;
            else if (phase == 1) n = 64;
            else n = eff * $urandom_range(1, 8) +
                     (($urandom_range(0, 3) == 0) ? $urandom_range(0, eff - 1) : 0);
            no_gaps = (phase % 4 == 2) || (phase == 1);
            if (phase == 1) hold_req = 1'b1;
            while (n > 0) begin
                burst = $urandom_range(1, 24);
                while (burst > 0 && n > 0) begin
                    send_pair(rand_elem(), rand_elem());
                    burst--;
                    n--;
                    total++;
                end
                gap = no_gaps ? 0 : $urandom_range(0, 6);
                if (gap > 0) begin
                    in_ch.valid = 1'b0;
                    repeat (gap) @(negedge i_clk);
                end
            end
            in_ch.valid = 1'b0;
            phase++;
        end

        wait_idle();
        repeat (20) @(negedge i_clk);
        if (distance_q.size() != 0) begin
            errors++;
            $display("%0t: %0d expected results never arrived, expected %h, got none",
                     $time, distance_q.size(), distance_q[0]);
        end
        if (errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/vda_pkg.sv
hw/rtl/vda_in_if.sv
hw/rtl/vda_out_if.sv
hw/rtl/vector_distance_accumulator.sv
tb/sv/vector_distance_accumulator_test.sv
